>>> hw/rtl/dvru_pkg.sv
// ----------------------------------------------------------------------------
// Distance-vector route update package
// Shared types, item kinds, action codes and sizing constants.
// ----------------------------------------------------------------------------
package dvru_pkg;

    localparam int TableDepthDefault = 64;
    localparam logic [4:0] InfHops = 5'd16;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_ADV  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NOP  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_IGNORED  = 3'd0,
        ACT_INSERTED = 3'd1,
        ACT_SAMEHOP  = 3'd2,
        ACT_REPLACED = 3'd3,
        ACT_LOADED   = 3'd4,
        ACT_FULL     = 3'd5,
        ACT_READ_OK  = 3'd6,
        ACT_READ_NO  = 3'd7
    } t_action;

    // one classified command passed from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] network;
        logic [4:0]  hops;
        logic [15:0] via_id;
        logic [5:0]  index;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_RD,
        ST_RD_WAIT,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/dvru_front.sv
// ----------------------------------------------------------------------------
// Distance-vector route update front end
// Accepts commands, clamps distances and queues them for the back end.
// ----------------------------------------------------------------------------
module dvru_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_kind,
    input  logic [31:0]     i_network,
    input  logic [7:0]      i_distance,
    input  logic [15:0]     i_next_hop,
    input  logic [5:0]      i_index,
    input  logic            i_pop,
    output logic            o_q_valid,
    output dvru_pkg::t_cmd  o_q_cmd
);

    logic           r_full;
    dvru_pkg::t_cmd r_cmd;
    dvru_pkg::t_cmd n_cmd;
    logic           w_acc;
    logic [7:0]     w_adv;

    // take a beat only into an empty slot
    assign w_acc     = i_start && !r_full;
    assign o_q_valid = r_full;
    assign o_q_cmd   = r_cmd;

    // classify and clamp
    always_comb begin
        w_adv = (i_distance >= 8'd15) ? 8'd16 : i_distance + 8'd1;
        n_cmd.kind    = dvru_pkg::t_kind'(i_kind);
        n_cmd.network = i_network;
        n_cmd.via_id  = i_next_hop;
        n_cmd.index   = i_index;
        if (dvru_pkg::t_kind'(i_kind) == dvru_pkg::KIND_ADV) begin
            n_cmd.hops = w_adv[4:0];
        end else if (i_distance > 8'd16) begin
            n_cmd.hops = dvru_pkg::InfHops;
        end else begin
            n_cmd.hops = i_distance[4:0];
        end
    end

    // fill on accept, drain when the back end pops
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (w_acc) begin
            r_full <= 1'b1;
        end else if (i_pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> hw/rtl/dvru_back.sv
// ----------------------------------------------------------------------------
// Distance-vector route update back end
// Holds the route table, scans it one entry a cycle and emits results.
// ----------------------------------------------------------------------------
module dvru_back #(
    parameter int TABLE_DEPTH = dvru_pkg::TableDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_neighbor_id,
    input  logic            i_q_valid,
    input  dvru_pkg::t_cmd  i_q_cmd,
    output logic            o_pop,
    output logic            o_done,
    output logic [2:0]      o_action,
    output logic [31:0]     o_out_network,
    output logic [4:0]      o_out_distance,
    output logic [15:0]     o_out_next_hop,
    output logic [6:0]      o_entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // table memory
    logic [31:0] r_mem_net [TABLE_DEPTH];
    logic [4:0]  r_mem_dist [TABLE_DEPTH];
    logic [15:0] r_mem_hop [TABLE_DEPTH];
    logic [31:0] r_rd_net;
    logic [4:0]  r_rd_dist;
    logic [15:0] r_rd_hop;
    logic [AW-1:0] w_raddr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wnet;
    logic [4:0]    w_wdist;
    logic [15:0]   w_whop;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_net[w_waddr]  <= w_wnet;
            r_mem_dist[w_waddr] <= w_wdist;
            r_mem_hop[w_waddr]  <= w_whop;
        end
        r_rd_net  <= r_mem_net[w_raddr];
        r_rd_dist <= r_mem_dist[w_raddr];
        r_rd_hop  <= r_mem_hop[w_raddr];
    end

    dvru_pkg::t_state r_state, n_state;
    dvru_pkg::t_cmd   r_cmd, n_cmd;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_chk, n_chk;
    logic             r_chk_v, n_chk_v;
    logic             r_found, n_found;
    logic [AW-1:0]    r_pos, n_pos;
    logic [2:0]       r_act, n_act;
    logic [31:0]      r_onet, n_onet;
    logic [4:0]       r_odist, n_odist;
    logic [15:0]      r_ohop, n_ohop;
    logic             r_done, n_done;
    logic             w_full;

    assign w_full = (r_count == CW'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvru_pkg::ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ptr   <= n_ptr;
        r_chk   <= n_chk;
        r_chk_v <= n_chk_v;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_act   <= n_act;
        r_onet  <= n_onet;
        r_odist <= n_odist;
        r_ohop  <= n_ohop;
    end

    // sequence each command: no-op answers at once, load writes, read fetches, advertise scans, then decides and writes
    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_chk   = r_chk;
        n_chk_v = 1'b0;
        n_found = r_found;
        n_pos   = r_pos;
        n_act   = r_act;
        n_onet  = r_onet;
        n_odist = r_odist;
        n_ohop  = r_ohop;
        n_done  = 1'b0;
        o_pop   = 1'b0;
        w_raddr = r_ptr[AW-1:0];
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wnet  = r_cmd.network;
        w_wdist = r_cmd.hops;
        w_whop  = r_cmd.via_id;
        case (r_state)
            dvru_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_ptr   = '0;
                    n_found = 1'b0;
                    case (i_q_cmd.kind)
                        dvru_pkg::KIND_LOAD: n_state = dvru_pkg::ST_DONE;
                        dvru_pkg::KIND_ADV:  n_state = dvru_pkg::ST_SCAN;
                        dvru_pkg::KIND_READ: n_state = dvru_pkg::ST_RD;
                        default: begin
                            n_act   = dvru_pkg::ACT_IGNORED;
                            n_onet  = '0;
                            n_odist = '0;
                            n_ohop  = '0;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
            dvru_pkg::ST_SCAN: begin
                // compare the entry read last cycle, issue the next read
                if (r_chk_v && r_rd_net == r_cmd.network) begin
                    n_found = 1'b1;
                    n_pos   = r_chk[AW-1:0];
                end
                if (r_ptr < r_count) begin
                    n_chk   = r_ptr;
                    n_chk_v = 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                end else begin
                    w_raddr = r_pos;
                    if (r_chk_v && r_rd_net == r_cmd.network) begin
                        w_raddr = r_chk[AW-1:0];
                    end
                    n_state = dvru_pkg::ST_SCAN_WAIT;
                end
            end
            dvru_pkg::ST_SCAN_WAIT: begin
                n_state = dvru_pkg::ST_IDLE;
                n_done  = 1'b1;
                w_waddr = r_pos;
                if (!r_found) begin
                    if (r_cmd.hops == dvru_pkg::InfHops) begin
                        n_act = dvru_pkg::ACT_IGNORED;
                        n_onet = '0; n_odist = '0; n_ohop = '0;
                    end else if (w_full) begin
                        n_act = dvru_pkg::ACT_FULL;
                        n_onet = r_cmd.network; n_odist = r_cmd.hops;
                        n_ohop = i_neighbor_id;
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = r_count[AW-1:0];
                        w_whop  = i_neighbor_id;
                        n_count = r_count + 1'b1;
                        n_act = dvru_pkg::ACT_INSERTED;
                        n_onet = r_cmd.network; n_odist = r_cmd.hops;
                        n_ohop = i_neighbor_id;
                    end
                end else if (r_rd_hop == i_neighbor_id || r_cmd.hops < r_rd_dist) begin
                    w_we   = 1'b1;
                    w_whop = i_neighbor_id;
                    n_act  = (r_rd_hop == i_neighbor_id) ? dvru_pkg::ACT_SAMEHOP
                                                         : dvru_pkg::ACT_REPLACED;
                    n_onet = r_cmd.network; n_odist = r_cmd.hops;
                    n_ohop = i_neighbor_id;
                end else begin
                    n_act = dvru_pkg::ACT_IGNORED;
                    n_onet = r_rd_net; n_odist = r_rd_dist; n_ohop = r_rd_hop;
                end
            end
            dvru_pkg::ST_RD: begin
                w_raddr = AW'(r_cmd.index);
                n_state = dvru_pkg::ST_RD_WAIT;
            end
            dvru_pkg::ST_RD_WAIT: begin
                n_state = dvru_pkg::ST_IDLE;
                n_done  = 1'b1;
                if ({{CW{1'b0}}, r_cmd.index} < {6'd0, r_count}
                        && {{CW{1'b0}}, r_cmd.index} < (CW + 6)'(TABLE_DEPTH)) begin
                    n_act = dvru_pkg::ACT_READ_OK;
                    n_onet = r_rd_net; n_odist = r_rd_dist; n_ohop = r_rd_hop;
                end else begin
                    n_act = dvru_pkg::ACT_READ_NO;
                    n_onet = '0; n_odist = '0; n_ohop = '0;
                end
            end
            dvru_pkg::ST_DONE: begin
                // load a local route
                n_state = dvru_pkg::ST_IDLE;
                n_done  = 1'b1;
                n_onet  = r_cmd.network;
                n_odist = r_cmd.hops;
                n_ohop  = r_cmd.via_id;
                if (w_full) begin
                    n_act = dvru_pkg::ACT_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_act   = dvru_pkg::ACT_LOADED;
                end
            end
            default: n_state = dvru_pkg::ST_IDLE;
        endcase
    end

    assign o_done         = r_done;
    assign o_action       = r_act;
    assign o_out_network  = r_onet;
    assign o_out_distance = r_odist;
    assign o_out_next_hop = r_ohop;
    assign o_entry_count  = 7'(r_count);

endmodule

>>> hw/rtl/distance_vector_route_update_core.sv
// ----------------------------------------------------------------------------
// Distance-vector route update core
// Route table engine: load, advertise and read commands, one result each.
// ----------------------------------------------------------------------------
// Channel   | Handshake          | Beat
// command   | i_start / o_busy   | kind, network, distance, next_hop, index
// result    | o_done strobe      | action, out_network, distance, next_hop, count
// config    | APB psel/penable   | neighbor_id at address 0
// Each accepted command yields one result beat; advertise scans the valid
// entries with the one-entry-per-cycle table scan on the single memory read
// port. Busy drops in the cycle after the result beat, when the next accept
// can follow.
// Reset clears the entry count and neighbor_id; table contents need no clearing.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module distance_vector_route_update_core #(
    parameter int TABLE_DEPTH = dvru_pkg::TableDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_network,
    input  logic [7:0]  i_distance,
    input  logic [15:0] i_next_hop,
    input  logic [5:0]  i_index,
    output logic        o_done,
    output logic [2:0]  o_action,
    output logic [31:0] o_out_network,
    output logic [4:0]  o_out_distance,
    output logic [15:0] o_out_next_hop,
    output logic [6:0]  o_entry_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]    r_neighbor_id;
    logic           w_q_valid;
    logic           w_pop;
    dvru_pkg::t_cmd w_q_cmd;
    logic           r_busy;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, r_neighbor_id} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_id <= '0;
        end else if (psel && penable && pwrite && paddr == 1'b0) begin
            r_neighbor_id <= pwdata[15:0];
        end
    end

    // hold busy from accept until the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
    assign o_busy = r_busy;

    dvru_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start && !r_busy),
        .i_kind     (i_kind),
        .i_network  (i_network),
        .i_distance (i_distance),
        .i_next_hop (i_next_hop),
        .i_index    (i_index),
        .i_pop      (w_pop),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd)
    );

    dvru_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_neighbor_id  (r_neighbor_id),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_pop          (w_pop),
        .o_done         (o_done),
        .o_action       (o_action),
        .o_out_network  (o_out_network),
        .o_out_distance (o_out_distance),
        .o_out_next_hop (o_out_next_hop),
        .o_entry_count  (o_entry_count)
    );

endmodule

>>> sim/distance_vector_route_update_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector route update core testbench
// Drives load, advertise, read and no-op commands through the start/busy
// handshake and checks every result beat against a route table predictor.
// The neighbor register is rewritten between phases over the APB port.
// ----------------------------------------------------------------------------
module distance_vector_route_update_core_test;

    localparam int Depth = 64;
    localparam int CycleLimit = 1000000;

    typedef struct {
        dvru_pkg::t_kind kind;
        logic [31:0]     network;
        logic [7:0]      distance;
        logic [15:0]     via_id;
        logic [5:0]      index;
    } t_route_cmd;

    typedef struct {
        dvru_pkg::t_action action;
        logic [31:0]       network;
        logic [4:0]        distance;
        logic [15:0]       via_id;
        logic [6:0]        count;
    } t_route_result;

    typedef struct {
        t_route_cmd    cmd;
        bit            typed;
        t_route_result want;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_network = '0;
    logic [7:0]  i_distance = '0;
    logic [15:0] i_next_hop = '0;
    logic [5:0]  i_index = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic        paddr = 1'b0;
    logic [31:0] pwdata = '0;
    logic        o_busy;
    logic        o_done;
    logic [2:0]  o_action;
    logic [31:0] o_out_network;
    logic [4:0]  o_out_distance;
    logic [15:0] o_out_next_hop;
    logic [6:0]  o_entry_count;
    logic [31:0] prdata;
    logic        pready;

    distance_vector_route_update_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_kind(i_kind), .i_network(i_network), .i_distance(i_distance),
        .i_next_hop(i_next_hop), .i_index(i_index), .o_done(o_done),
        .o_action(o_action), .o_out_network(o_out_network),
        .o_out_distance(o_out_distance), .o_out_next_hop(o_out_next_hop),
        .o_entry_count(o_entry_count), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // route table mirror
    logic [31:0] tbl_network [Depth];
    logic [4:0]  tbl_distance [Depth];
    logic [15:0] tbl_next_hop [Depth];
    int unsigned tbl_count = 0;
    logic [15:0] cur_neighbor = '0;

    t_route_result pending_results[$];
    int unsigned   error_count = 0;
    int unsigned   cycle_count = 0;
    logic [31:0]   net_pool [40];
    logic [15:0]   hop_pool [6];
    t_directed_row directed_rows [15];

    function automatic t_route_result make_result(dvru_pkg::t_action act,
                                                  logic [31:0] net,
                                                  logic [4:0] hops, logic [15:0] hop);
        t_route_result r;
        r.action = act;
        r.network = net;
        r.distance = hops;
        r.via_id = hop;
        r.count = tbl_count[6:0];
        return r;
    endfunction

    // apply one command to the mirror and return the result it yields
    function automatic t_route_result apply_route_cmd(t_route_cmd c);
        int unsigned cand;
        int unsigned ld;
        int          hit;
        hit = -1;
        case (c.kind)
            dvru_pkg::KIND_LOAD: begin
                ld = (c.distance > dvru_pkg::InfHops) ? dvru_pkg::InfHops : c.distance;
                if (tbl_count >= Depth)
                    return make_result(dvru_pkg::ACT_FULL, c.network, ld[4:0], c.via_id);
                tbl_network[tbl_count] = c.network;
                tbl_distance[tbl_count] = ld[4:0];
                tbl_next_hop[tbl_count] = c.via_id;
                tbl_count++;
                return make_result(dvru_pkg::ACT_LOADED, c.network, ld[4:0], c.via_id);
            end
            dvru_pkg::KIND_ADV: begin
                cand = c.distance + 1;
                if (cand > dvru_pkg::InfHops) cand = dvru_pkg::InfHops;
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_network[i] == c.network) hit = i;
                if (hit < 0) begin
                    if (cand >= dvru_pkg::InfHops)
                        return make_result(dvru_pkg::ACT_IGNORED, '0, '0, '0);
                    if (tbl_count >= Depth)
                        return make_result(dvru_pkg::ACT_FULL, c.network, cand[4:0],
                                           cur_neighbor);
                    tbl_network[tbl_count] = c.network;
                    tbl_distance[tbl_count] = cand[4:0];
                    tbl_next_hop[tbl_count] = cur_neighbor;
                    tbl_count++;
                    return make_result(dvru_pkg::ACT_INSERTED, c.network, cand[4:0],
                                       cur_neighbor);
                end
                if (tbl_next_hop[hit] == cur_neighbor) begin
                    tbl_distance[hit] = cand[4:0];
                    return make_result(dvru_pkg::ACT_SAMEHOP, c.network, cand[4:0],
                                       cur_neighbor);
                end
                if (cand < tbl_distance[hit]) begin
                    tbl_distance[hit] = cand[4:0];
                    tbl_next_hop[hit] = cur_neighbor;
                    return make_result(dvru_pkg::ACT_REPLACED, c.network, cand[4:0],
                                       cur_neighbor);
                end
                return make_result(dvru_pkg::ACT_IGNORED, tbl_network[hit],
                                   tbl_distance[hit], tbl_next_hop[hit]);
            end
            dvru_pkg::KIND_READ: begin
                if (c.index < tbl_count)
                    return make_result(dvru_pkg::ACT_READ_OK, tbl_network[c.index],
                                       tbl_distance[c.index], tbl_next_hop[c.index]);
                return make_result(dvru_pkg::ACT_READ_NO, '0, '0, '0);
            end
            default: return make_result(dvru_pkg::ACT_IGNORED, '0, '0, '0);
        endcase
    endfunction

    // present one beat, hold until accepted, then drop start
    task automatic send_cmd(t_route_cmd c, bit typed, t_route_result want);
        t_route_result got;
        bit taken;
        taken = 1'b0;
        i_kind = c.kind;
        i_network = c.network;
        i_distance = c.distance;
        i_next_hop = c.via_id;
        i_index = c.index;
        i_start = 1'b1;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_busy;
        end
        got = apply_route_cmd(c);
        pending_results.insert(pending_results.size(), typed ? want : got);
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic write_neighbor(logic [15:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = 1'b0;
        pwdata = {16'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cur_neighbor = value;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0 || o_busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic t_route_cmd random_cmd();
        t_route_cmd c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 22) c.kind = dvru_pkg::KIND_LOAD;
        else if (pick < 72) c.kind = dvru_pkg::KIND_ADV;
        else if (pick < 95) c.kind = dvru_pkg::KIND_READ;
        else c.kind = dvru_pkg::KIND_NOP;
        c.network = ($urandom_range(0, 9) == 0) ? $urandom() : net_pool[$urandom_range(0, 39)];
        c.distance = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 17));
        c.via_id = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                               : hop_pool[$urandom_range(0, 5)];
        c.index = ($urandom_range(0, 3) == 0) ? 6'($urandom())
                                              : 6'($urandom_range(0, tbl_count));
        return c;
    endfunction

    // check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_route_result w;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result action=%0d net=%h", $realtime, o_action,
                         o_out_network);
                error_count++;
            end else begin
                w = pending_results.pop_front();
                if (o_action !== w.action || o_out_network !== w.network ||
                    o_out_distance !== w.distance || o_out_next_hop !== w.via_id ||
                    o_entry_count !== w.count) begin
                    $display("%0t: expected act=%0d net=%h dist=%0d hop=%h cnt=%0d",
                             $realtime, w.action, w.network, w.distance, w.via_id,
                             w.count);
                    $display("%0t: actual   act=%0d net=%h dist=%0d hop=%h cnt=%0d",
                             $realtime, o_action, o_out_network, o_out_distance,
                             o_out_next_hop, o_entry_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        t_route_result none;
        logic [15:0] nb_settings [6];
        int unsigned idle_pct;
        none = '{dvru_pkg::ACT_IGNORED, '0, '0, '0, '0};
        for (int i = 0; i < 40; i++) net_pool[i] = $urandom();
        net_pool[0] = 32'h0;
        net_pool[1] = 32'hFFFF_FFFF;
        nb_settings = '{16'h0000, 16'hFFFF, 16'h0005, 16'h0007, 16'($urandom()), 16'h0000};
        hop_pool = '{16'h0000, 16'hFFFF, 16'h0005, 16'h0007, nb_settings[4], 16'h1234};

        // directed rows: typed where the result is plain from the table state
        directed_rows[0]  = '{'{dvru_pkg::KIND_READ, 32'h0, 8'd0, 16'h0, 6'd0}, 1,
                              '{dvru_pkg::ACT_READ_NO, 32'h0, 5'd0, 16'h0, 7'd0}};
        directed_rows[1]  = '{'{dvru_pkg::KIND_LOAD, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 6'd63},
                              1, '{dvru_pkg::ACT_LOADED, 32'hFFFF_FFFF, 5'd16, 16'hFFFF,
                                   7'd1}};
        directed_rows[2]  = '{'{dvru_pkg::KIND_LOAD, 32'h0, 8'd0, 16'h0, 6'd0}, 1,
                              '{dvru_pkg::ACT_LOADED, 32'h0, 5'd0, 16'h0, 7'd2}};
        directed_rows[3]  = '{'{dvru_pkg::KIND_NOP, 32'hFFFF_FFFF, 8'd255, 16'hFFFF, 6'd63},
                              1, '{dvru_pkg::ACT_IGNORED, 32'h0, 5'd0, 16'h0, 7'd2}};
        directed_rows[4]  = '{'{dvru_pkg::KIND_ADV, 32'h0, 8'd0, 16'h0, 6'd0}, 1,
                              '{dvru_pkg::ACT_SAMEHOP, 32'h0, 5'd1, 16'h0, 7'd2}};
        directed_rows[5]  = '{'{dvru_pkg::KIND_ADV, 32'h1234_5678, 8'd15, 16'h0, 6'd0}, 1,
                              '{dvru_pkg::ACT_IGNORED, 32'h0, 5'd0, 16'h0, 7'd2}};
        directed_rows[6]  = '{'{dvru_pkg::KIND_ADV, 32'h1234_5678, 8'd2, 16'h0, 6'd0}, 0,
                              none};
        directed_rows[7]  = '{'{dvru_pkg::KIND_ADV, 32'hFFFF_FFFF, 8'd255, 16'h0, 6'd0}, 0,
                              none};
        directed_rows[8]  = '{'{dvru_pkg::KIND_ADV, 32'hFFFF_FFFF, 8'd3, 16'h0, 6'd0}, 0,
                              none};
        directed_rows[9]  = '{'{dvru_pkg::KIND_ADV, 32'hFFFF_FFFF, 8'd20, 16'h0, 6'd0}, 0,
                              none};
        directed_rows[10] = '{'{dvru_pkg::KIND_LOAD, 32'h0, 8'd17, 16'hA5A5, 6'd0}, 0, none};
        directed_rows[11] = '{'{dvru_pkg::KIND_ADV, 32'h0, 8'd4, 16'h0, 6'd0}, 0, none};
        directed_rows[12] = '{'{dvru_pkg::KIND_LOAD, 32'h5A5A_A5A5, 8'd16, 16'h5A5A, 6'd0}, 0,
                              none};
        directed_rows[13] = '{'{dvru_pkg::KIND_READ, 32'h0, 8'd0, 16'h0, 6'd3}, 0, none};
        directed_rows[14] = '{'{dvru_pkg::KIND_READ, 32'h0, 8'd0, 16'h0, 6'd63}, 1,
                              '{dvru_pkg::ACT_READ_NO, 32'h0, 5'd0, 16'h0, 7'd5}};

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        write_neighbor(16'h0000);

        foreach (directed_rows[r])
            send_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
        for (int i = 0; i < 5; i++)
            send_cmd('{dvru_pkg::KIND_READ, 32'h0, 8'd0, 16'h0, 6'(i)}, 0, none);

        // random phases, each rewriting the neighbor and picking a sender idling level
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            write_neighbor(nb_settings[ph]);
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 83;
                default: idle_pct = 21;
            endcase
            for (int n = 0; n < 285; n++) begin
                send_cmd(random_cmd(), 0, none);
                if ($urandom_range(0, 99) < idle_pct)
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
